[hw/rtl/hdc_pkg.sv]
package hdc_pkg;

	// Angle format and behavioural constants.
	localparam int MAX_DETENTS     = 1024;
	localparam int ANGLE_FRAC_BITS = 6;
	localparam int RESYNC_TIMEOUT  = 1000;
	localparam int GUARD_MIN       = 30 << ANGLE_FRAC_BITS;
	localparam int FREE_RESYNC     = 2 << ANGLE_FRAC_BITS;
	localparam int DEADBAND        = 3;
	localparam int HID_MAX         = 1023;

	// Shared divider geometry.
	localparam int DIV_W     = 28;
	localparam int DEN_W     = 18;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SPAN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DETENT_TOTAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DETENT_GAIN  = 3'd4;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_FIRST,
		OP_SNAP_FREE,
		OP_SET_IDX0,
		OP_DIV_IDX,
		OP_TAKE_IDX,
		OP_DIV_POS,
		OP_TAKE_POS,
		OP_MUL_GUARD,
		OP_MUL_DEV,
		OP_TIMES10,
		OP_RESYNC_END,
		OP_INC,
		OP_DEC,
		OP_MUL_BLEND,
		OP_BLEND_ISSUE,
		OP_FREE_TRACK,
		OP_DIV_HID_DET,
		OP_DIV_HID_FREE,
		OP_HID_ZERO,
		OP_HID_MAX,
		OP_TAKE_HID,
		OP_EMIT
	} op_t;

	// Status flags returned to the controller.
	typedef struct packed {
		logic div_done;
		logic enable;
		logic cmd;
		logic first;
		logic n_zero;
		logic span_zero;
		logic frozen;
		logic resync;
		logic near;
		logic timeout;
		logic step_up;
		logic step_down;
		logic gain_full;
		logic x_neg;
		logic x_big;
		logic out_busy;
	} status_t;

endpackage

[hw/rtl/haptic_detent_controller.sv]
// A transaction runs from acceptance until its result is presented. A snap with detents
// runs the shared radix-2 divider up to three times in turn: for the index, the position
// and the HID level.
// Throughput: one transaction at a time; the next is accepted at the edge after the result
// is loaded into the output register, which waits while an earlier result is stalled.
// Reset: asynchronous, active low; control and configuration registers take their defaults.
module haptic_detent_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [hdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic signed [23:0]             motor_angle,
	input  logic signed [23:0]             request_angle,
	input  logic [31:0]                    now_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [23:0]             target_angle,
	output logic                           target_written,
	output logic signed [11:0]             detent_index,
	output logic [9:0]                     hid_level,
	output logic                           resync_active
);

	hdc_pkg::op_t     op;
	hdc_pkg::status_t status;

	hdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	hdc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.motor_angle    (motor_angle),
		.request_angle  (request_angle),
		.now_ms         (now_ms),
		.op             (op),
		.status         (status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_angle   (target_angle),
		.target_written (target_written),
		.detent_index   (detent_index),
		.hid_level      (hid_level),
		.resync_active  (resync_active)
	);

endmodule

[hw/rtl/hdc_div.sv]
module hdc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [hdc_pkg::DIV_W-1:0]      num,
	input  logic [hdc_pkg::DEN_W-1:0]      den,
	output logic                           done,
	output logic [hdc_pkg::DIV_W-1:0]      quot
);

	logic                             busy_q;
	logic                             done_q;
	logic [hdc_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [hdc_pkg::DEN_W-1:0]        den_q;
	logic [hdc_pkg::DEN_W-1:0]        rem_q;
	logic [hdc_pkg::DIV_W-1:0]        quo_q;
	logic [hdc_pkg::DEN_W:0]          trial;
	logic                             fits;

	// One quotient bit per cycle, restoring.
	assign trial = {rem_q, quo_q[hdc_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == hdc_pkg::DIV_CNT_W'(hdc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? hdc_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[hdc_pkg::DEN_W-1:0];
			quo_q <= {quo_q[hdc_pkg::DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[hw/rtl/hdc_datapath.sv]
module hdc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [hdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              command,
	input  logic signed [23:0]                motor_angle,
	input  logic signed [23:0]                request_angle,
	input  logic [31:0]                       now_ms,
	input  hdc_pkg::op_t                      op,
	output hdc_pkg::status_t                  status,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [23:0]                target_angle,
	output logic                              target_written,
	output logic signed [11:0]                detent_index,
	output logic [9:0]                        hid_level,
	output logic                              resync_active
);

	// Configuration registers.
	logic               enable_q;
	logic [15:0]        span_q;
	logic signed [15:0] center_q;
	logic [10:0]        total_q;
	logic [8:0]         gain_q;

	// Controller state.
	logic               first_q;
	logic               resync_q;
	logic [31:0]        start_q;
	logic [10:0]        pos_q;
	logic signed [23:0] snapped_q;
	logic signed [23:0] commanded_q;

	// Per-transaction working registers.
	logic               cmd_q;
	logic signed [23:0] ang_q;
	logic [31:0]        now_q;
	logic               written_q;
	logic [35:0]        prod_q;
	logic [39:0]        p10_q;
	logic signed [35:0] bprod_q;
	logic [9:0]         hid_q;

	// Result register.
	logic               out_valid_q;
	logic signed [23:0] out_target_q;
	logic               out_written_q;
	logic signed [11:0] out_index_q;
	logic [9:0]         out_hid_q;
	logic               out_resync_q;

	// Combinational datapath.
	logic [10:0]                   n_det;
	logic signed [25:0]            lo;
	logic signed [25:0]            hi;
	logic signed [25:0]            ang_w;
	logic signed [25:0]            eff;
	logic [25:0]                   guard_dist;
	logic signed [25:0]            snap_w;
	logic signed [25:0]            cmd_w;
	logic signed [25:0]            dev;
	logic [25:0]                   adev;
	logic signed [25:0]            x_off;
	logic signed [25:0]            eff_off;
	logic [35:0]                   mul_a;
	logic [35:0]                   mul_b;
	logic [35:0]                   mul_p;
	logic [26:0]                   idx_prod;
	logic [26:0]                   pos_prod;
	logic [27:0]                   hid_det_num;
	logic [27:0]                   hid_free_num;
	logic signed [25:0]            bdiff;
	logic signed [35:0]            gain_x;
	logic signed [35:0]            bdiff_x;
	logic signed [35:0]            bshift;
	logic signed [35:0]            t_blend;
	logic signed [35:0]            t_diff;
	logic signed [25:0]            f_diff;
	logic                          blend_issue;
	logic                          free_issue;
	logic [17:0]                   span2;
	logic [17:0]                   span3;
	logic [18:0]                   span6;
	logic signed [25:0]            pos_target;
	logic                          div_start;
	logic [hdc_pkg::DIV_W-1:0]     div_num;
	logic [hdc_pkg::DEN_W-1:0]     div_den;
	logic                          div_done;
	logic [hdc_pkg::DIV_W-1:0]     div_quot;

	// Throw edges and the clamped angle.
	assign n_det  = (total_q > 11'(hdc_pkg::MAX_DETENTS)) ? 11'(hdc_pkg::MAX_DETENTS) : total_q;
	assign lo     = $signed({{10{center_q[15]}}, center_q}) - $signed({11'd0, span_q[15:1]});
	assign hi     = lo + $signed({10'd0, span_q});
	assign ang_w  = {{2{ang_q[23]}}, ang_q};
	assign eff    = (ang_w < lo) ? lo : ((ang_w > hi) ? hi : ang_w);
	assign guard_dist = (ang_w > hi) ? 26'(ang_w - hi)
		: ((ang_w < lo) ? 26'(lo - ang_w) : 26'd0);
	assign snap_w = {{2{snapped_q[23]}}, snapped_q};
	assign cmd_w  = {{2{commanded_q[23]}}, commanded_q};
	assign dev    = eff - snap_w;
	assign adev   = dev[25] ? 26'(-dev) : 26'(dev);
	assign x_off  = snap_w - lo;
	assign eff_off = eff - lo;

	assign span2 = {1'b0, span_q, 1'b0};
	assign span3 = {2'b00, span_q} + {1'b0, span_q, 1'b0};
	assign span6 = {span3, 1'b0};

	// The shared multiplier: guard distance or deviation times the detent count.
	assign mul_a = (op == hdc_pkg::OP_MUL_GUARD) ? {11'd0, guard_dist[24:0]} : {11'd0, adev[24:0]};
	assign mul_b = {25'd0, n_det};
	assign mul_p = mul_a * mul_b;

	// Divider operands.
	assign idx_prod     = {11'd0, eff_off[15:0]} * {16'd0, n_det};
	assign pos_prod     = {16'd0, pos_q} * {11'd0, span_q};
	assign hid_det_num  = {17'd0, pos_q} * 28'(hdc_pkg::HID_MAX);
	assign hid_free_num = {12'd0, x_off[15:0]} * 28'(hdc_pkg::HID_MAX);

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (op)
			hdc_pkg::OP_DIV_IDX: begin
				div_start = 1'b1;
				div_num   = {idx_prod, 1'b0} + {12'd0, span_q};
				div_den   = span2;
			end
			hdc_pkg::OP_DIV_POS: begin
				div_start = 1'b1;
				div_num   = {pos_prod, 1'b0} + {17'd0, n_det};
				div_den   = {6'd0, n_det, 1'b0};
			end
			hdc_pkg::OP_DIV_HID_DET: begin
				div_start = 1'b1;
				div_num   = hid_det_num;
				div_den   = {7'd0, n_det};
			end
			hdc_pkg::OP_DIV_HID_FREE: begin
				div_start = 1'b1;
				div_num   = hid_free_num;
				div_den   = {2'd0, span_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	hdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Blend toward the snapped target by the detent strength.
	assign bdiff       = snap_w - eff;
	assign gain_x      = {27'd0, gain_q};
	assign bdiff_x     = {{10{bdiff[25]}}, bdiff};
	assign bshift      = (bprod_q + 36'sd128) >>> 8;
	assign t_blend     = {{10{eff[25]}}, eff} + bshift;
	assign t_diff      = t_blend - {{10{cmd_w[25]}}, cmd_w};
	assign blend_issue = (t_diff > 36'(hdc_pkg::DEADBAND)) || (t_diff < -36'(hdc_pkg::DEADBAND));
	assign f_diff      = eff - cmd_w;
	assign free_issue  = (f_diff > 26'(hdc_pkg::DEADBAND)) || (f_diff < -26'(hdc_pkg::DEADBAND));

	assign pos_target = lo + $signed({1'b0, div_quot[24:0]});

	// Configuration and state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			span_q      <= 16'd11520;
			center_q    <= 16'sd5760;
			total_q     <= 11'd18;
			gain_q      <= 9'd256;
			first_q     <= 1'b1;
			resync_q    <= 1'b0;
			start_q     <= '0;
			pos_q       <= '0;
			snapped_q   <= '0;
			commanded_q <= '0;
			written_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					hdc_pkg::REG_ENABLE: begin
						enable_q <= cfg_data[0];
						first_q  <= 1'b1;
					end
					hdc_pkg::REG_RANGE_SPAN: begin
						span_q  <= cfg_data;
						first_q <= 1'b1;
					end
					hdc_pkg::REG_CENTER: begin
						center_q <= $signed(cfg_data);
						first_q  <= 1'b1;
					end
					hdc_pkg::REG_DETENT_TOTAL: begin
						total_q <= cfg_data[10:0];
						first_q <= 1'b1;
					end
					hdc_pkg::REG_DETENT_GAIN: begin
						gain_q <= cfg_data[8:0];
					end
					default: begin
					end
				endcase
			end
			case (op)
				hdc_pkg::OP_LOAD: begin
					written_q <= 1'b0;
				end
				hdc_pkg::OP_CLR_FIRST: begin
					first_q <= 1'b0;
				end
				hdc_pkg::OP_SNAP_FREE: begin
					pos_q       <= '0;
					snapped_q   <= eff[23:0];
					commanded_q <= eff[23:0];
					written_q   <= 1'b1;
					resync_q    <= 1'b1;
					start_q     <= now_q;
				end
				hdc_pkg::OP_SET_IDX0: begin
					pos_q <= '0;
				end
				hdc_pkg::OP_TAKE_IDX: begin
					pos_q <= (div_quot > {17'd0, n_det}) ? n_det : div_quot[10:0];
				end
				hdc_pkg::OP_TAKE_POS: begin
					snapped_q   <= pos_target[23:0];
					commanded_q <= pos_target[23:0];
					written_q   <= 1'b1;
					resync_q    <= 1'b1;
					start_q     <= now_q;
				end
				hdc_pkg::OP_RESYNC_END: begin
					resync_q <= 1'b0;
					start_q  <= '0;
				end
				hdc_pkg::OP_INC: begin
					pos_q <= pos_q + 1'b1;
				end
				hdc_pkg::OP_DEC: begin
					pos_q <= pos_q - 1'b1;
				end
				hdc_pkg::OP_BLEND_ISSUE: begin
					if (blend_issue) begin
						commanded_q <= t_blend[23:0];
						written_q   <= 1'b1;
					end
				end
				hdc_pkg::OP_FREE_TRACK: begin
					snapped_q <= eff[23:0];
					if (free_issue) begin
						commanded_q <= eff[23:0];
						written_q   <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			// Result register valid flag.
			if (op == hdc_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		case (op)
			hdc_pkg::OP_LOAD: begin
				cmd_q <= command;
				ang_q <= command ? request_angle : motor_angle;
				now_q <= now_ms;
			end
			hdc_pkg::OP_MUL_GUARD, hdc_pkg::OP_MUL_DEV: begin
				prod_q <= mul_p;
			end
			hdc_pkg::OP_TIMES10: begin
				p10_q <= ({4'd0, prod_q} << 3) + ({4'd0, prod_q} << 1);
			end
			hdc_pkg::OP_MUL_BLEND: begin
				bprod_q <= gain_x * bdiff_x;
			end
			hdc_pkg::OP_HID_ZERO: begin
				hid_q <= '0;
			end
			hdc_pkg::OP_HID_MAX: begin
				hid_q <= 10'(hdc_pkg::HID_MAX);
			end
			hdc_pkg::OP_TAKE_HID: begin
				hid_q <= (div_quot > 28'(hdc_pkg::HID_MAX)) ? 10'(hdc_pkg::HID_MAX) : div_quot[9:0];
			end
			hdc_pkg::OP_EMIT: begin
				out_target_q  <= commanded_q;
				out_written_q <= written_q;
				out_index_q   <= (!enable_q || n_det == 11'd0) ? -12'sd1 : $signed({1'b0, pos_q});
				out_hid_q     <= hid_q;
				out_resync_q  <= resync_q;
			end
			default: begin
			end
		endcase
	end

	// Status towards the controller.
	always_comb begin
		status.div_done  = div_done;
		status.enable    = enable_q;
		status.cmd       = cmd_q;
		status.first     = first_q;
		status.n_zero    = (n_det == 11'd0);
		status.span_zero = (span_q == 16'd0);
		status.frozen    = (guard_dist > 26'(hdc_pkg::GUARD_MIN))
			&& (n_det == 11'd0 || prod_q > {18'd0, span2});
		status.resync    = resync_q;
		status.near      = (n_det != 11'd0) ? (p10_q < {22'd0, span3})
			: (adev < 26'(hdc_pkg::FREE_RESYNC));
		status.timeout   = (now_q - start_q) > 32'(hdc_pkg::RESYNC_TIMEOUT);
		status.step_up   = !dev[25] && (dev != 26'sd0) && (p10_q > {21'd0, span6})
			&& (pos_q < n_det);
		status.step_down = dev[25] && (p10_q > {21'd0, span6}) && (pos_q != 11'd0);
		status.gain_full = gain_q[8];
		status.x_neg     = x_off[25];
		status.x_big     = x_off >= $signed({10'd0, span_q});
		status.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid      = out_valid_q;
	assign target_angle   = out_target_q;
	assign target_written = out_written_q;
	assign detent_index   = out_index_q;
	assign hid_level      = out_hid_q;
	assign resync_active  = out_resync_q;

	// A loaded result is always presented on the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(op == hdc_pkg::OP_EMIT) |=> out_valid_q)
		else $error("result not presented after load");

	// The detent index never passes the detent count.
	a_pos_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(op == hdc_pkg::OP_TAKE_IDX || op == hdc_pkg::OP_INC) |=> (pos_q <= $past(n_det)))
		else $error("detent index beyond detent count");

	// A new detent target is issued and starts a resync.
	a_pos_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(op == hdc_pkg::OP_TAKE_POS) |=> (resync_q && written_q && commanded_q == snapped_q))
		else $error("detent target not issued with resync");

endmodule

[hw/rtl/hdc_ctrl.sv]
module hdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hdc_pkg::status_t status,
	output hdc_pkg::op_t     op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SNAP,
		S_IDX_WAIT,
		S_POS_START,
		S_POS_WAIT,
		S_GUARD_MUL,
		S_GUARD_CHK,
		S_DEV_X10,
		S_DECIDE,
		S_BLEND,
		S_HID,
		S_HID_WAIT,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	// Sequencing of datapath operations for one transaction.
	always_comb begin
		state_d = state_q;
		op      = hdc_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = hdc_pkg::OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!status.enable) begin
					state_d = S_HID;
				end else if (status.cmd || status.first) begin
					if (!status.cmd) begin
						op = hdc_pkg::OP_CLR_FIRST;
					end
					state_d = S_SNAP;
				end else begin
					state_d = S_GUARD_MUL;
				end
			end
			S_SNAP: begin
				if (status.n_zero) begin
					op      = hdc_pkg::OP_SNAP_FREE;
					state_d = S_HID;
				end else if (status.span_zero) begin
					op      = hdc_pkg::OP_SET_IDX0;
					state_d = S_POS_START;
				end else begin
					op      = hdc_pkg::OP_DIV_IDX;
					state_d = S_IDX_WAIT;
				end
			end
			S_IDX_WAIT: begin
				if (status.div_done) begin
					op      = hdc_pkg::OP_TAKE_IDX;
					state_d = S_POS_START;
				end
			end
			S_POS_START: begin
				op      = hdc_pkg::OP_DIV_POS;
				state_d = S_POS_WAIT;
			end
			S_POS_WAIT: begin
				if (status.div_done) begin
					op      = hdc_pkg::OP_TAKE_POS;
					state_d = S_HID;
				end
			end
			S_GUARD_MUL: begin
				op      = hdc_pkg::OP_MUL_GUARD;
				state_d = S_GUARD_CHK;
			end
			S_GUARD_CHK: begin
				if (status.frozen) begin
					state_d = S_HID;
				end else begin
					op      = hdc_pkg::OP_MUL_DEV;
					state_d = S_DEV_X10;
				end
			end
			S_DEV_X10: begin
				op      = hdc_pkg::OP_TIMES10;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_HID;
				if (status.resync) begin
					if (status.near || status.timeout) begin
						op = hdc_pkg::OP_RESYNC_END;
					end
				end else if (status.n_zero) begin
					op = hdc_pkg::OP_FREE_TRACK;
				end else if (status.step_up) begin
					op      = hdc_pkg::OP_INC;
					state_d = S_POS_START;
				end else if (status.step_down) begin
					op      = hdc_pkg::OP_DEC;
					state_d = S_POS_START;
				end else if (!status.gain_full) begin
					op      = hdc_pkg::OP_MUL_BLEND;
					state_d = S_BLEND;
				end
			end
			S_BLEND: begin
				op      = hdc_pkg::OP_BLEND_ISSUE;
				state_d = S_HID;
			end
			S_HID: begin
				if (!status.n_zero) begin
					op      = hdc_pkg::OP_DIV_HID_DET;
					state_d = S_HID_WAIT;
				end else if (status.span_zero || status.x_neg) begin
					op      = hdc_pkg::OP_HID_ZERO;
					state_d = S_EMIT;
				end else if (status.x_big) begin
					op      = hdc_pkg::OP_HID_MAX;
					state_d = S_EMIT;
				end else begin
					op      = hdc_pkg::OP_DIV_HID_FREE;
					state_d = S_HID_WAIT;
				end
			end
			S_HID_WAIT: begin
				if (status.div_done) begin
					op      = hdc_pkg::OP_TAKE_HID;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!status.out_busy) begin
					op      = hdc_pkg::OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

	// One result of the block, held at port widths.
	typedef struct packed {
		logic signed [23:0] target;
		logic               written;
		logic signed [11:0] index;
		logic [9:0]         hid;
		logic               resync;
	} knob_result_t;

	// One row of the directed table; typed rows carry a hand-worked result.
	typedef struct {
		bit          cmd;
		int          motor;
		int          request;
		bit [31:0]   stamp;
		bit          typed;
		knob_result_t res;
	} knob_row_t;

	// One register setting per phase of the run.
	typedef struct {
		int en;
		int span;
		int centre;
		int total;
		int gain;
	} knob_setting_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write;
	logic [hdc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hdc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic                           command;
	logic signed [23:0]             motor_angle;
	logic signed [23:0]             request_angle;
	logic [31:0]                    now_ms;
	logic                           out_valid;
	logic                           out_stall;
	logic signed [23:0]             target_angle;
	logic                           target_written;
	logic signed [11:0]             detent_index;
	logic [9:0]                     hid_level;
	logic                           resync_active;

	haptic_detent_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .motor_angle(motor_angle),
		.request_angle(request_angle), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.target_angle(target_angle), .target_written(target_written),
		.detent_index(detent_index), .hid_level(hid_level),
		.resync_active(resync_active)
	);

	// Mirror of the configuration registers.
	longint m_en, m_span, m_centre, m_total, m_gain;
	// Mirror of the controller state.
	bit        m_first, m_resync;
	bit [31:0] m_resync_start;
	longint    m_dpos, m_snapped, m_commanded;

	knob_result_t expected_results[$];
	knob_result_t drv_res;
	bit           drv_typed;
	int           accepted_items, checked_results, mismatches, idle_cycles;
	int           burst_left, hold_cycles;
	bit           hold_req;
	bit [31:0]    clock_ms;

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint abs_l(longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint detents();
		return m_total > hdc_pkg::MAX_DETENTS ? hdc_pkg::MAX_DETENTS : m_total;
	endfunction

	function automatic longint throw_lo();
		return m_centre - (m_span >> 1);
	endfunction

	function automatic longint clamp_throw(longint a);
		longint lo, hi;
		lo = throw_lo();
		hi = lo + m_span;
		return a < lo ? lo : (a > hi ? hi : a);
	endfunction

	function automatic longint detent_angle(longint idx);
		longint n;
		n = detents();
		return throw_lo() + (2 * idx * m_span + n) / (2 * n);
	endfunction

	// Snap to the nearest detent (or the clamped angle), issue it and start a resync.
	function automatic void snap_target(longint a, bit [31:0] stamp, ref bit wr);
		longint n, eff, idx;
		n = detents();
		eff = clamp_throw(a);
		if (n == 0) begin
			m_dpos = 0;
			m_snapped = eff;
		end else begin
			idx = 0;
			if (m_span != 0)
				idx = (2 * (eff - throw_lo()) * n + m_span) / (2 * m_span);
			if (idx > n)
				idx = n;
			m_dpos = idx;
			m_snapped = detent_angle(idx);
		end
		m_commanded = m_snapped;
		wr = 1;
		m_resync = 1;
		m_resync_start = stamp;
	endfunction

	// Periodic tick: guard band, resync, detent stepping, blending and free tracking.
	function automatic void tick_target(longint m, bit [31:0] stamp, ref bit wr);
		longint n, lo, hi, eff, dev, d, t, g;
		bit near;
		bit [31:0] elapsed;
		n = detents();
		lo = throw_lo();
		hi = lo + m_span;
		if (m_first) begin
			snap_target(m, stamp, wr);
			m_first = 0;
			return;
		end
		d = m > hi ? m - hi : (m < lo ? lo - m : 0);
		if (d > hdc_pkg::GUARD_MIN && (n == 0 || d * n > 2 * m_span))
			return;
		eff = clamp_throw(m);
		dev = eff - m_snapped;
		if (m_resync) begin
			near = n > 0 ? abs_l(dev) * n * 10 < 3 * m_span
				: abs_l(dev) < hdc_pkg::FREE_RESYNC;
			elapsed = stamp - m_resync_start;
			if (near || elapsed > hdc_pkg::RESYNC_TIMEOUT) begin
				m_resync = 0;
				m_resync_start = 0;
			end
			return;
		end
		if (n > 0) begin
			if (dev * n * 10 > 6 * m_span && m_dpos < n) begin
				m_dpos++;
			end else if (-dev * n * 10 > 6 * m_span && m_dpos > 0) begin
				m_dpos--;
			end else begin
				g = m_gain > 256 ? 256 : m_gain;
				if (g < 256) begin
					t = eff + floor_div(g * (m_snapped - eff) + 128, 256);
					if (abs_l(t - m_commanded) > hdc_pkg::DEADBAND) begin
						m_commanded = t;
						wr = 1;
					end
				end
				return;
			end
			m_snapped = detent_angle(m_dpos);
			m_commanded = m_snapped;
			wr = 1;
			m_resync = 1;
			m_resync_start = stamp;
		end else begin
			m_snapped = eff;
			if (abs_l(eff - m_commanded) > hdc_pkg::DEADBAND) begin
				m_commanded = eff;
				wr = 1;
			end
		end
	endfunction

	// Expected result of one transaction; updates the mirrored state.
	function automatic knob_result_t predict_knob(bit cmd, longint m, longint r,
			bit [31:0] stamp);
		knob_result_t res;
		bit wr;
		longint n, hid;
		wr = 0;
		if (m_en != 0) begin
			if (cmd)
				snap_target(r, stamp, wr);
			else
				tick_target(m, stamp, wr);
		end
		n = detents();
		if (n > 0)
			hid = m_dpos * 1023 / n;
		else if (m_span == 0)
			hid = 0;
		else
			hid = floor_div((m_snapped - throw_lo()) * 1023, m_span);
		if (hid < 0)
			hid = 0;
		if (hid > hdc_pkg::HID_MAX)
			hid = hdc_pkg::HID_MAX;
		res.target = m_commanded[23:0];
		res.written = wr;
		res.index = (m_en == 0 || n == 0) ? -12'sd1 : m_dpos[11:0];
		res.hid = hid[9:0];
		res.resync = m_resync;
		return res;
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Mirror register writes, predict accepted transactions and check results.
	always @(posedge clk or negedge arst_n) begin
		knob_result_t res, want;
		if (!arst_n) begin
			m_en = 1; m_span = 11520; m_centre = 5760; m_total = 18; m_gain = 256;
			m_first = 1; m_resync = 0; m_resync_start = 0;
			m_dpos = 0; m_snapped = 0; m_commanded = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					hdc_pkg::REG_ENABLE: begin m_en = cfg_data[0]; m_first = 1; end
					hdc_pkg::REG_RANGE_SPAN: begin m_span = cfg_data; m_first = 1; end
					hdc_pkg::REG_CENTER: begin m_centre = $signed(cfg_data); m_first = 1; end
					hdc_pkg::REG_DETENT_TOTAL: begin m_total = cfg_data[10:0]; m_first = 1; end
					hdc_pkg::REG_DETENT_GAIN: m_gain = cfg_data[8:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				res = predict_knob(command, motor_angle, request_angle, now_ms);
				if (drv_typed)
					res = drv_res;
				expected_results.push_back(res);
				accepted_items <= accepted_items + 1;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, target %0d", $time, target_angle);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (want.target !== target_angle) begin
						$display("%0t: target_angle expected %0d actual %0d",
							$time, want.target, target_angle);
						mismatches++;
					end
					if (want.written !== target_written) begin
						$display("%0t: target_written expected %0d actual %0d",
							$time, want.written, target_written);
						mismatches++;
					end
					if (want.index !== detent_index) begin
						$display("%0t: detent_index expected %0d actual %0d",
							$time, want.index, detent_index);
						mismatches++;
					end
					if (want.hid !== hid_level) begin
						$display("%0t: hid_level expected %0d actual %0d",
							$time, want.hid, hid_level);
						mismatches++;
					end
					if (want.resync !== resync_active) begin
						$display("%0t: resync_active expected %0d actual %0d",
							$time, want.resync, resync_active);
						mismatches++;
					end
				end
				checked_results++;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: stall pattern in segments of varying density, plus one long hold-off.
	initial begin
		int seg, density;
		out_stall = 0;
		seg = 0;
		density = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_cycles == 0)
				hold_cycles = 2500;
			if (hold_cycles > 0) begin
				out_stall = 1;
				hold_cycles--;
				if (hold_cycles == 0)
					hold_req = 0;
			end else begin
				if (seg == 0) begin
					seg = $urandom_range(5, 80);
					density = $urandom_range(0, 3) * 30;
				end
				seg--;
				out_stall = $urandom_range(0, 99) < density;
			end
		end
	end

	// Drive one transaction in the sender's burst pattern and wait until it is taken.
	task automatic send_item(bit cmd, int m, int r, bit [31:0] stamp, bit typed,
			knob_result_t res);
		int goal;
		if (burst_left == 0) begin
			in_valid = 0;
			drv_typed = 0;
			repeat ($urandom_range(1, 25)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid = 1;
		command = cmd;
		motor_angle = m;
		request_angle = r;
		now_ms = stamp;
		drv_typed = typed;
		drv_res = res;
		goal = accepted_items + 1;
		do @(negedge clk); while (accepted_items != goal);
		burst_left--;
	endtask

	task automatic write_reg(logic [hdc_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_write = 1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 0;
	endtask

	// Wait until every result has arrived and the block has settled.
	task automatic drain();
		in_valid = 0;
		drv_typed = 0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	function automatic int sat24(longint a);
		return a > 8388607 ? 8388607 : (a < -8388608 ? -8388608 : int'(a));
	endfunction

	// Random angle: mostly around the current detent, some near the throw edges,
	// some anywhere in the 24-bit range.
	function automatic int pick_angle();
		longint n, st, lo, hi;
		int mode;
		n = detents();
		st = (n > 0) ? m_span / n : 256;
		if (st < 8)
			st = 8;
		lo = throw_lo();
		hi = lo + m_span;
		mode = $urandom_range(0, 9);
		if (mode == 0)
			return $signed($urandom() & 32'hFFFFFF) <<< 8 >>> 8;
		if (mode <= 2)
			return sat24((mode == 1 ? lo : hi)
				+ $urandom_range(0, 2 * hdc_pkg::GUARD_MIN + 4 * st)
				- hdc_pkg::GUARD_MIN - 2 * st);
		return sat24(m_snapped + $urandom_range(0, 2 * st) - st);
	endfunction

	knob_row_t rows[17];
	knob_setting_t phases[9];

	initial begin
		knob_result_t none;
		int m, r, cmd;
		none = '0;
		arst_n = 0;
		cfg_write = 0;
		cfg_index = hdc_pkg::REG_ENABLE;
		cfg_data = 0;
		in_valid = 0;
		command = 0;
		motor_angle = 0;
		request_angle = 0;
		now_ms = 0;
		drv_typed = 0;
		drv_res = '0;
		accepted_items = 0;
		checked_results = 0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		hold_cycles = 0;
		hold_req = 0;

		// Directed table on the reset settings: throw 0..11520, 18 detents of 640.
		rows = '{
			'{0, 0, 0, 0, 1, '{24'sd0, 1'b1, 12'sd0, 10'd0, 1'b1}},
			'{0, 100, 0, 10, 0, none},
			'{0, 500, 0, 20, 0, none},
			'{0, 640, 0, 30, 0, none},
			'{0, 100, 0, 35, 0, none},
			'{0, -3000, 0, 40, 0, none},
			'{0, 8388607, 0, 50, 0, none},
			'{1, 0, 8388607, 60, 1, '{24'sd11520, 1'b1, 12'sd18, 10'd1023, 1'b1}},
			'{0, 11520, 0, 70, 0, none},
			'{0, 14000, 0, 80, 0, none},
			'{0, 13000, 0, 90, 0, none},
			'{1, 0, -8388608, 100, 1, '{24'sd0, 1'b1, 12'sd0, 10'd0, 1'b1}},
			'{0, 5000, 0, 200, 0, none},
			'{0, 5000, 0, 1101, 0, none},
			'{0, 5000, 0, 1102, 0, none},
			'{0, -8388608, 0, 32'hFFFFFFFF, 0, none},
			'{1, -1, 3200, 32'hFFFFFFFF, 0, none}
		};
		phases = '{
			'{1, 11520, 5760, 18, 256},
			'{1, 11520, 5760, 18, 128},
			'{1, 11520, 0, 1024, 0},
			'{1, 4000, -1000, 0, 200},
			'{1, 0, 100, 5, 64},
			'{1, 65535, -32768, 2047, 511},
			'{1, 64, 32767, 1, 255},
			'{0, 11520, 5760, 18, 256},
			'{1, 65535, 32767, 3, 100}
		};

		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (rows[i])
			send_item(rows[i].cmd, rows[i].motor, rows[i].request, rows[i].stamp,
				rows[i].typed, rows[i].res);
		drain();

		// Random phases, each under its own register setting.
		foreach (phases[p]) begin
			write_reg(hdc_pkg::REG_ENABLE, phases[p].en);
			write_reg(hdc_pkg::REG_RANGE_SPAN, phases[p].span);
			write_reg(hdc_pkg::REG_CENTER, phases[p].centre);
			write_reg(hdc_pkg::REG_DETENT_TOTAL, phases[p].total);
			write_reg(hdc_pkg::REG_DETENT_GAIN, phases[p].gain);
			@(negedge clk);
			clock_ms = (p == 2) ? 32'hFFFFF000 : $urandom();
			if (p == 1)
				hold_req = 1;
			repeat (90) begin
				case ($urandom_range(0, 19))
					0: clock_ms = $urandom();
					1, 2: clock_ms += $urandom_range(900, 1200);
					default: clock_ms += $urandom_range(0, 300);
				endcase
				cmd = $urandom_range(0, 9) == 0;
				m = pick_angle();
				r = cmd ? pick_angle() : ($signed($urandom() & 32'hFFFFFF) <<< 8 >>> 8);
				send_item(cmd, m, r, clock_ms, 0, none);
			end
			drain();
		end

		$display("Run covered %0d transactions and %0d results over %0d register settings,",
			accepted_items, checked_results, 10);
		$display("including snaps, steps, blends, free rotation, freezes and resync timeouts.");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
